FILE: design/assert_macros.svh
// Assertion macros shared by the timer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/udht_pkg.sv
// Types and constants shared by the hours:minutes:seconds timer
`timescale 1ns / 1ps
package udht_pkg;

  localparam int unsigned MAX_HOURS = 99;

  localparam logic [5:0]  SEC_MAX  = 6'd59;
  localparam logic [5:0]  MIN_MAX  = 6'd59;
  localparam logic [6:0]  HOUR_MAX = 7'(MAX_HOURS);

  localparam logic [15:0] IDLE_SAT       = 16'hFFFF;
  localparam logic [15:0] IDLE_LIMIT_RST = 16'd60;

  localparam int unsigned CFG_ADDR_W = 3;

  // Register select, taken from paddr[2]
  localparam logic REG_SOUND_ENABLE = 1'b0;
  localparam logic REG_IDLE_LIMIT   = 1'b1;

  // Event codes
  localparam logic [2:0] KIND_TICK       = 3'd0;
  localparam logic [2:0] KIND_START_STOP = 3'd1;
  localparam logic [2:0] KIND_AMBER      = 3'd2;
  localparam logic [2:0] KIND_RED        = 3'd3;
  localparam logic [2:0] KIND_EXIT       = 3'd4;
  localparam logic [2:0] KIND_LOAD       = 3'd5;

  typedef enum logic [1:0] {
    INC_SEC,
    INC_MIN,
    INC_HOUR
  } inc_op_t;

  typedef struct packed {
    logic [6:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } time_t;

  localparam time_t TIME_SAT = '{hours: HOUR_MAX, minutes: MIN_MAX, seconds: SEC_MAX};

  typedef struct packed {
    logic [2:0] kind;
    logic [5:0] load_seconds;
    logic [5:0] load_minutes;
    logic [6:0] load_hours;
  } in_item_t;

  typedef struct packed {
    logic [5:0] sec_out;
    logic [5:0] min_out;
    logic [6:0] hour_out;
    logic       is_running;
    logic       is_counting_up;
    logic       alert_pulse;
    logic       done_res;
  } out_item_t;

  typedef struct packed {
    logic        sound_enable;
    logic [15:0] idle_limit;
  } cfg_t;

endpackage

FILE: design/udht_cfg_regs.sv
// APB configuration registers: sound_enable and idle_limit
`timescale 1ns / 1ps
module udht_cfg_regs import udht_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic        sound_enable_r;
  logic [15:0] idle_limit_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sound_enable_r <= 1'b1;
      idle_limit_r   <= IDLE_LIMIT_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_SOUND_ENABLE: sound_enable_r <= pwdata[0];
        REG_IDLE_LIMIT:   idle_limit_r   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SOUND_ENABLE: prdata = {31'd0, sound_enable_r};
      REG_IDLE_LIMIT:   prdata = {16'd0, idle_limit_r};
      default:          prdata = '0;
    endcase
  end

  assign cfg.sound_enable = sound_enable_r;
  assign cfg.idle_limit   = idle_limit_r;

endmodule

FILE: design/udht_time_math.sv
// Saturating increment and floored decrement of an hh:mm:ss value
`timescale 1ns / 1ps
module udht_time_math import udht_pkg::*; (
  input  time_t   cur,
  input  inc_op_t op,
  output time_t   inc_time,
  output time_t   dec_time,
  output logic    cur_zero,
  output logic    dec_zero
);

  assign cur_zero = (cur == '0);
  assign dec_zero = (dec_time == '0);

  // Any carry out of the hours digit clamps to the full-scale time
  always_comb begin
    inc_time = cur;
    case (op)
      INC_SEC: begin
        if (cur.seconds != SEC_MAX) begin
          inc_time.seconds = cur.seconds + 6'd1;
        end else if (cur.minutes != MIN_MAX) begin
          inc_time.seconds = '0;
          inc_time.minutes = cur.minutes + 6'd1;
        end else if (cur.hours != HOUR_MAX) begin
          inc_time.seconds = '0;
          inc_time.minutes = '0;
          inc_time.hours   = cur.hours + 7'd1;
        end else begin
          inc_time = TIME_SAT;
        end
      end
      INC_MIN: begin
        if (cur.minutes != MIN_MAX) begin
          inc_time.minutes = cur.minutes + 6'd1;
        end else if (cur.hours != HOUR_MAX) begin
          inc_time.minutes = '0;
          inc_time.hours   = cur.hours + 7'd1;
        end else begin
          inc_time = TIME_SAT;
        end
      end
      INC_HOUR: begin
        if (cur.hours != HOUR_MAX) begin
          inc_time.hours = cur.hours + 7'd1;
        end else begin
          inc_time = TIME_SAT;
        end
      end
      default: inc_time = cur;
    endcase
  end

  always_comb begin
    dec_time = cur;
    if (!cur_zero) begin
      if (cur.seconds != '0) begin
        dec_time.seconds = cur.seconds - 6'd1;
      end else begin
        dec_time.seconds = SEC_MAX;
        if (cur.minutes != '0) begin
          dec_time.minutes = cur.minutes - 6'd1;
        end else begin
          dec_time.minutes = MIN_MAX;
          dec_time.hours   = cur.hours - 7'd1;
        end
      end
    end
  end

endmodule

FILE: design/udht_state.sv
// Timer state registers and per-event next-state logic
`timescale 1ns / 1ps
module udht_state import udht_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t result
);

  time_t       time_r, time_nxt;
  logic        run_r, run_nxt;
  logic        up_r, up_nxt;
  logic [15:0] idle_r, idle_nxt;
  logic        done_r, done_nxt;
  logic        alert;

  inc_op_t     op;
  time_t       inc_time, dec_time;
  logic        cur_zero, dec_zero;
  logic [15:0] idle_inc;
  logic        hours_zero;

  assign hours_zero = (time_r.hours == '0);
  assign idle_inc   = (idle_r != IDLE_SAT) ? idle_r + 16'd1 : idle_r;

  // Amber and red step a coarser digit once hours are nonzero
  always_comb begin
    case (item.kind)
      KIND_AMBER: op = hours_zero ? INC_MIN : INC_HOUR;
      KIND_RED:   op = hours_zero ? INC_SEC : INC_MIN;
      default:    op = INC_SEC;
    endcase
  end

  udht_time_math u_math (
    .cur      (time_r),
    .op       (op),
    .inc_time (inc_time),
    .dec_time (dec_time),
    .cur_zero (cur_zero),
    .dec_zero (dec_zero)
  );

  always_comb begin
    time_nxt = time_r;
    run_nxt  = run_r;
    up_nxt   = up_r;
    idle_nxt = idle_r;
    done_nxt = done_r;
    alert    = 1'b0;
    if (item.kind == KIND_LOAD) begin
      time_nxt.seconds = (item.load_seconds > SEC_MAX) ? SEC_MAX : item.load_seconds;
      time_nxt.minutes = (item.load_minutes > MIN_MAX) ? MIN_MAX : item.load_minutes;
      time_nxt.hours   = (item.load_hours > HOUR_MAX) ? HOUR_MAX : item.load_hours;
      run_nxt  = 1'b0;
      up_nxt   = 1'b0;
      idle_nxt = '0;
      done_nxt = 1'b0;
    end else if (!done_r) begin
      case (item.kind) inside
        KIND_TICK: begin
          if (run_r) begin
            if (up_r) begin
              time_nxt = inc_time;
            end else begin
              time_nxt = dec_time;
              if (dec_zero) begin
                run_nxt  = 1'b0;
                idle_nxt = '0;
                alert    = cfg.sound_enable;
              end
            end
          end else begin
            idle_nxt = idle_inc;
            if (idle_inc >= cfg.idle_limit) done_nxt = 1'b1;
          end
        end
        KIND_START_STOP: begin
          idle_nxt = '0;
          if (!run_r) begin
            run_nxt = 1'b1;
            up_nxt  = cur_zero;
          end else begin
            run_nxt = 1'b0;
          end
        end
        KIND_AMBER, KIND_RED: begin
          idle_nxt = '0;
          time_nxt = inc_time;
        end
        KIND_EXIT: done_nxt = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r <= '0;
      run_r  <= 1'b0;
      up_r   <= 1'b0;
      idle_r <= '0;
      done_r <= 1'b0;
    end else if (step) begin
      time_r <= time_nxt;
      run_r  <= run_nxt;
      up_r   <= up_nxt;
      idle_r <= idle_nxt;
      done_r <= done_nxt;
    end
  end

  assign result.sec_out        = time_nxt.seconds;
  assign result.min_out        = time_nxt.minutes;
  assign result.hour_out       = time_nxt.hours;
  assign result.is_running     = run_nxt;
  assign result.is_counting_up = up_nxt;
  assign result.alert_pulse    = alert;
  assign result.done_res       = done_nxt;

endmodule

FILE: design/up_down_hms_timer_core.sv
// Top level of the up/down hours:minutes:seconds timer
//
// Input channel (in_valid/in_ready/in_data): one event per transaction, a
// one-second tick, a button (start_stop, amber, red, exit) or a load of a
// new time. Every event returns exactly one result on the output channel
// (out_valid/out_ready/out_data): the time, run and direction flags, the
// alert pulse and the done flag, all as they stand after the event.
// An event passes through the input register, then through the next-state
// logic into the output register.
// Throughput is one event per cycle while out_ready is not held low; the
// time update is a single carry/borrow pass over the three digits.
// The input register frees up whenever its event moves to the output
// register, so a new event is taken while a result waits for out_ready.
// When the receiver stalls, the result holds and in_ready drops once the
// input register is also full.
// Reset clears the time, flags and idle count and sets sound_enable to 1 and
// idle_limit to 60. The user must write the APB registers only while the
// timer has no transaction in flight; the block itself does not enforce it.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module up_down_hms_timer_core import udht_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t      cfg;
  in_item_t  in_item_r;
  logic      in_valid_r;
  out_item_t out_item_r;
  logic      out_valid_r;
  out_item_t result;
  logic      step;

  assign step     = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || step;

  udht_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  udht_state u_state (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (in_item_r),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_item_r <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) out_item_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  `ASSERT_IMPLIES(a_stall_only_on_out, clk, rst_n, !in_ready, out_valid && !out_ready, "in_ready low without an output stall")
  `ASSERT_NEXT(a_step_gives_result, clk, rst_n, step, out_valid, "advanced transaction produced no result")
  `ASSERT_IMPLIES(a_alert_at_zero, clk, rst_n, out_valid && out_data.alert_pulse, !out_data.is_running && out_data.sec_out == '0 && out_data.min_out == '0 && out_data.hour_out == '0, "alert without a stopped zero time")
  `ASSERT_IMPLIES(a_time_in_range, clk, rst_n, out_valid, out_data.sec_out <= SEC_MAX && out_data.min_out <= MIN_MAX && out_data.hour_out <= HOUR_MAX, "time digit out of range")

endmodule
